/* sv/ghash_gf128_accumulator_core_assert.svh */
// Assertion macros used by the GHASH accumulator back end (gga_back).
`ifndef GHASH_GF128_ACCUMULATOR_CORE_ASSERT_SVH
`define GHASH_GF128_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GGA_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("gga assertion failed");

// Next-cycle implication, disabled during reset.
`define GGA_ASSERT_NXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("gga assertion failed");

`endif

/* sv/gga_pkg.sv */
//------------------------------------------------------------------------------
// gga_pkg
// Types and constants shared by the GHASH GF(2^128) accumulator.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package gga_pkg;

   localparam int BLOCK_BYTES = 16;

   localparam logic [1:0] FUNC_ABSORB  = 2'd0;
   localparam logic [1:0] FUNC_FINAL   = 2'd1;
   localparam logic [1:0] FUNC_PARTIAL = 2'd2;

   localparam logic [1:0] CMD_ABSORB  = 2'd0;
   localparam logic [1:0] CMD_FINAL   = 2'd1;
   localparam logic [1:0] CMD_PARTIAL = 2'd2;

   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   localparam logic [127:0] GF_POLY = {8'hE1, 120'd0};

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } gga_req_type;

   typedef struct packed {
      logic [63:0] hash_high;
      logic [63:0] hash_low;
   } gga_rsp_type;

   typedef struct packed {
      logic [1:0]   kind;
      logic         has_part;
      logic [127:0] block;
      logic [63:0]  bit_count;
   } gga_cmd_type;

endpackage

/* sv/gga_front.sv */
//------------------------------------------------------------------------------
// gga_front
// Packs message bytes into blocks, keeps the bit count, issues commands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module gga_front
   import gga_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  gga_req_type req_data,
   output logic        req_full,
   output logic        cmd_push,
   output gga_cmd_type cmd_data,
   input  logic        cmd_full
);

   logic [127:0] block_ff, block_in;
   logic [3:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic [127:0] block_wr;
   logic         take;

   assign req_full = cmd_full;
   assign take     = req_push && !cmd_full;

   always_comb begin
      block_wr = block_ff;
      block_wr[8*(15 - fill_ff) +: 8] = req_data.data_byte;
   end

   always_comb begin
      block_in = block_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      cmd_push = 1'b0;
      cmd_data = '{kind: CMD_ABSORB, has_part: 1'b1, block: block_wr, bit_count: bits_ff};
      if (take) begin
         case (req_data.func)
            FUNC_ABSORB: begin
               bits_in = bits_ff + 64'd8;
               fill_in = fill_ff + 4'd1;
               if (fill_ff == 4'd15) begin
                  cmd_push = 1'b1;
                  block_in = '0;
               end else begin
                  block_in = block_wr;
               end
            end
            FUNC_FINAL, FUNC_PARTIAL: begin
               cmd_push = 1'b1;
               cmd_data.kind     = (req_data.func == FUNC_FINAL) ? CMD_FINAL : CMD_PARTIAL;
               cmd_data.has_part = (fill_ff != 4'd0);
               cmd_data.block    = block_ff;
               if (req_data.func == FUNC_FINAL) begin
                  block_in = '0;
                  fill_in  = '0;
                  bits_in  = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff <= '0;
         fill_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         block_ff <= block_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
   end

endmodule

/* sv/gga_cmd_fifo.sv */
//------------------------------------------------------------------------------
// gga_cmd_fifo
// Two-entry command queue between the byte packer and the multiplier.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module gga_cmd_fifo
   import gga_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  gga_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output gga_cmd_type pop_data,
   output logic        empty
);

   gga_cmd_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff ^ do_push;
   assign rd_ptr_in = rd_ptr_ff ^ do_pop;
   assign count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/gga_back.sv */
//------------------------------------------------------------------------------
// gga_back
// Bit-serial GF(2^128) multiply by H, accumulator, key and result register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module gga_back
   import gga_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   input  gga_cmd_type cmd_data,
   input  logic        cmd_empty,
   output logic        cmd_pop,
   output gga_rsp_type rsp_data,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   `include "ghash_gf128_accumulator_core_assert.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] key_ff, key_in;
   logic [127:0] acc_ff, acc_in;
   logic [127:0] a_ff, a_in;
   logic [127:0] z_ff, z_in;
   logic [127:0] v_ff, v_in;
   logic [1:0]   kind_ff, kind_in;
   logic         has_part_ff, has_part_in;
   logic         pass_ff, pass_in;
   logic [63:0]  len_ff, len_in;
   gga_rsp_type  out_ff, out_in;
   logic         out_vld_ff, out_vld_in;
   logic [127:0] z_step, v_step;
   logic [127:0] len_blk;

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_vld_ff;
   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;

   assign z_step = a_ff[127] ? (z_ff ^ v_ff) : z_ff;
   assign v_step = {1'b0, v_ff[127:1]} ^ (v_ff[0] ? GF_POLY : 128'd0);

   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_HIGH: key_in[127:64] = csr_data;
            CSR_KEY_LOW:  key_in[63:0]   = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      a_in        = a_ff;
      z_in        = z_ff;
      v_in        = v_ff;
      kind_in     = kind_ff;
      has_part_in = has_part_ff;
      pass_in     = pass_ff;
      len_in      = len_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !rsp_pop;
      len_blk     = {64'd0, cmd_data.bit_count};
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               kind_in     = cmd_data.kind;
               has_part_in = cmd_data.has_part;
               len_in      = cmd_data.bit_count;
               pass_in     = 1'b0;
               cnt_in      = '0;
               z_in        = '0;
               v_in        = key_ff;
               a_in        = acc_ff ^ ((cmd_data.kind == CMD_ABSORB || cmd_data.has_part) ?
                                       cmd_data.block : len_blk);
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            a_in   = {a_ff[126:0], 1'b0};
            z_in   = z_step;
            v_in   = v_step;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               if (kind_ff == CMD_ABSORB) begin
                  acc_in   = z_step;
                  state_in = ST_IDLE;
               end else if (has_part_ff && !pass_ff) begin
                  a_in    = z_step ^ {64'd0, len_ff};
                  z_in    = '0;
                  v_in    = key_ff;
                  pass_in = 1'b1;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!out_vld_ff || rsp_pop) begin
               out_in     = '{hash_high: z_ff[127:64], hash_low: z_ff[63:0]};
               out_vld_in = 1'b1;
               if (kind_ff == CMD_FINAL) begin
                  acc_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         key_ff     <= '0;
         acc_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         key_ff     <= key_in;
         acc_ff     <= acc_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      z_ff        <= z_in;
      v_ff        <= v_in;
      kind_ff     <= kind_in;
      has_part_ff <= has_part_in;
      pass_ff     <= pass_in;
      len_ff      <= len_in;
      out_ff      <= out_in;
   end

   `GGA_ASSERT_IMP(a_pop_only_idle, cmd_pop, state_ff == ST_IDLE)
   `GGA_ASSERT_NXT(a_start_counts_zero, state_ff == ST_IDLE && !cmd_empty,
                   state_ff == ST_MUL && cnt_ff == 7'd0)
   `GGA_ASSERT_NXT(a_out_waits, state_ff == ST_OUT && out_vld_ff && !rsp_pop,
                   state_ff == ST_OUT)
   `GGA_ASSERT_NXT(a_absorb_no_result, state_ff == ST_MUL && kind_ff == CMD_ABSORB &&
                   !out_vld_ff && !rsp_pop, !out_vld_ff)

endmodule

/* sv/ghash_gf128_accumulator_core.sv */
//------------------------------------------------------------------------------
// ghash_gf128_accumulator_core
// GHASH over GF(2^128): byte packer, command queue and bit-serial multiplier.
//------------------------------------------------------------------------------
// Channel   Ports                               Direction
// request   req_push, req_full, req_data        in  (func, data_byte)
// response  rsp_pop, rsp_empty, rsp_data        out (hash_high, hash_low)
// csr       csr_we, csr_index, csr_data         in  (key_high, key_low)
//
// Each 16th byte queues one block command; the back end takes it in a dispatch
// step and then runs a bit-serial multiply, while bytes keep being packed until the queue fills.
// A finalize/partial result is ready after one multiply pass, or two with a
// pending partial block, once the multiplier is free.
// Reset is synchronous and clears state and key; no clearing pass.
// The two-entry command queue and the result register let each side stall.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghash_gf128_accumulator_core
   import gga_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  gga_req_type req_data,
   output logic        req_full,
   output gga_rsp_type rsp_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   gga_cmd_type cmd_in, cmd_out;

   gga_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in),
      .cmd_full (cmd_full)
   );

   gga_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   gga_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_data  (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule
